// File: rtl/wfd_pkg.sv
// Shared types, codes and helpers of the WebSocket frame deframer.
`timescale 1ns / 1ps

package wfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXTHI = 3'd2,
        PH_EXTLO = 3'd3,
        PH_DATA  = 3'd4
    } phase_t;

    localparam logic [2:0] KIND_HDR   = 3'd0;
    localparam logic [2:0] KIND_DATA  = 3'd1;
    localparam logic [2:0] KIND_EMPTY = 3'd2;
    localparam logic [2:0] KIND_ERR   = 3'd3;
    localparam logic [2:0] KIND_DROP  = 3'd4;

    localparam logic [2:0] FT_TEXT  = 3'd0;
    localparam logic [2:0] FT_PING  = 3'd1;
    localparam logic [2:0] FT_PONG  = 3'd2;
    localparam logic [2:0] FT_CLOSE = 3'd3;
    localparam logic [2:0] FT_OTHER = 3'd4;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_FRAG  = 3'd1;
    localparam logic [2:0] ERR_LEN64 = 3'd2;
    localparam logic [2:0] ERR_MASK  = 3'd3;
    localparam logic [2:0] ERR_LONG  = 3'd4;

    localparam logic [3:0] OPC_TEXT  = 4'h1;
    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [3:0] OPC_PING  = 4'h9;
    localparam logic [3:0] OPC_PONG  = 4'ha;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4095;

    // One result item.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [2:0] frame_type;
        logic       last;
        logic [2:0] error_code;
        logic       link_up;
    } result_t;

    function automatic logic [2:0] type_of(input logic [3:0] opc);
        logic [2:0] ft;
        case (opc)
            OPC_TEXT:  ft = FT_TEXT;
            OPC_PING:  ft = FT_PING;
            OPC_PONG:  ft = FT_PONG;
            OPC_CLOSE: ft = FT_CLOSE;
            default:   ft = FT_OTHER;
        endcase
        return ft;
    endfunction

endpackage

// File: rtl/websocket_frame_deframer_top.sv
// Top level of the WebSocket frame deframer: header parser, output register, config port.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (s_valid/s_ready, s_mode, s_rx_byte) carries one request per
//   received stream byte, or a connect request (s_mode = 1) that restarts the
//   parser and raises the link. Every request yields exactly one result on the
//   output channel (m_valid/m_ready, m_kind, m_data_byte, m_frame_type,
//   m_last, m_error_code, m_link_up_out).
//   Timing: the result is registered and shows in the cycle after acceptance.
//   Throughput: one request per cycle unless stalled; the parser state is updated by the
//   byte decode logic in the same cycle that the request is accepted.
//   Stall: the output register holds its result while m_ready is low; a new
//   request is taken only when the output register is empty or being drained
//   in that cycle, so s_ready follows m_ready while a result is pending.
//   Reset (aresetn low, synchronous): the link is down, the parser expects the
//   first header byte, the output register is empty and max_payload is 4095.
//   Configuration: APB register 0 at byte address 0 holds max_payload; write
//   it only while no request is in flight. pready is always high.
//   A protocol error or a completed close frame drops the link; bytes are then
//   answered as dropped until the next connect request.

module websocket_frame_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic [2:0]  m_frame_type,
    output logic        m_last,
    output logic [2:0]  m_error_code,
    output logic        m_link_up_out,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Parser state.
    wfd_pkg::phase_t phase_reg, phase_next;
    logic            link_up_reg, link_up_next;
    logic [3:0]      opcode_reg, opcode_next;
    logic            mask_seen_reg, mask_seen_next;
    logic [15:0]     remaining_reg, remaining_next;
    logic [7:0]      length_high_reg, length_high_next;
    logic [15:0]     max_payload_reg;

    // Output register.
    logic             m_valid_reg;
    wfd_pkg::result_t result_reg, result_next;

    logic        accept;
    logic        len_known;
    logic [15:0] known_len;
    logic        known_mask;
    logic [15:0] rem_dec;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= wfd_pkg::MAX_PAYLOAD_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            max_payload_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {16'd0, max_payload_reg} : 32'd0;

    // ---------------------------------------------------------------
    // Handshake: take a request whenever the output register frees up
    // ---------------------------------------------------------------
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign rem_dec = remaining_reg - 16'd1;

    // ---------------------------------------------------------------
    // Byte decode: next parser state and the result for this request
    // ---------------------------------------------------------------
    always_comb begin
        phase_next       = phase_reg;
        link_up_next     = link_up_reg;
        opcode_next      = opcode_reg;
        mask_seen_next   = mask_seen_reg;
        remaining_next   = remaining_reg;
        length_high_next = length_high_reg;
        len_known        = 1'b0;
        known_len        = 16'd0;
        known_mask       = 1'b0;

        result_next            = '0;
        result_next.kind       = wfd_pkg::KIND_HDR;
        result_next.error_code = wfd_pkg::ERR_NONE;

        if (s_mode) begin
            // Connect: raise the link and clear the frame state.
            link_up_next     = 1'b1;
            phase_next       = wfd_pkg::PH_HDR0;
            opcode_next      = 4'd0;
            mask_seen_next   = 1'b0;
            remaining_next   = 16'd0;
            length_high_next = 8'd0;
        end else if (!link_up_reg) begin
            result_next.kind = wfd_pkg::KIND_DROP;
        end else begin
            result_next.frame_type = wfd_pkg::type_of(opcode_reg);
            case (phase_reg)
                wfd_pkg::PH_HDR0: begin
                    opcode_next            = s_rx_byte[3:0];
                    result_next.frame_type = wfd_pkg::type_of(s_rx_byte[3:0]);
                    if (!s_rx_byte[7]) begin
                        result_next.kind       = wfd_pkg::KIND_ERR;
                        result_next.error_code = wfd_pkg::ERR_FRAG;
                        link_up_next           = 1'b0;
                        phase_next             = wfd_pkg::PH_HDR0;
                        remaining_next         = 16'd0;
                    end else begin
                        phase_next = wfd_pkg::PH_HDR1;
                    end
                end
                wfd_pkg::PH_HDR1: begin
                    mask_seen_next = s_rx_byte[7];
                    if (s_rx_byte[6:0] == wfd_pkg::LEN7_EXT16) begin
                        phase_next = wfd_pkg::PH_EXTHI;
                    end else if (s_rx_byte[6:0] == wfd_pkg::LEN7_EXT64) begin
                        result_next.kind       = wfd_pkg::KIND_ERR;
                        result_next.error_code = wfd_pkg::ERR_LEN64;
                        link_up_next           = 1'b0;
                        phase_next             = wfd_pkg::PH_HDR0;
                        remaining_next         = 16'd0;
                    end else begin
                        len_known  = 1'b1;
                        known_len  = {9'd0, s_rx_byte[6:0]};
                        known_mask = s_rx_byte[7];
                    end
                end
                wfd_pkg::PH_EXTHI: begin
                    length_high_next = s_rx_byte;
                    phase_next       = wfd_pkg::PH_EXTLO;
                end
                wfd_pkg::PH_EXTLO: begin
                    len_known  = 1'b1;
                    known_len  = {length_high_reg, s_rx_byte};
                    known_mask = mask_seen_reg;
                end
                wfd_pkg::PH_DATA: begin
                    result_next.kind      = wfd_pkg::KIND_DATA;
                    result_next.data_byte = s_rx_byte;
                    remaining_next        = rem_dec;
                    if (rem_dec == 16'd0) begin
                        result_next.last = 1'b1;
                        phase_next       = wfd_pkg::PH_HDR0;
                        if (opcode_reg == wfd_pkg::OPC_CLOSE) begin
                            link_up_next   = 1'b0;
                            remaining_next = 16'd0;
                        end
                    end
                end
                default: begin
                    phase_next = wfd_pkg::PH_HDR0;
                end
            endcase

            // Length settled: check mask, then limit, then end an empty frame or start payload.
            if (len_known) begin
                if (known_mask) begin
                    result_next.kind       = wfd_pkg::KIND_ERR;
                    result_next.error_code = wfd_pkg::ERR_MASK;
                    link_up_next           = 1'b0;
                    phase_next             = wfd_pkg::PH_HDR0;
                    remaining_next         = 16'd0;
                end else if (known_len > max_payload_reg) begin
                    result_next.kind       = wfd_pkg::KIND_ERR;
                    result_next.error_code = wfd_pkg::ERR_LONG;
                    link_up_next           = 1'b0;
                    phase_next             = wfd_pkg::PH_HDR0;
                    remaining_next         = 16'd0;
                end else if (known_len == 16'd0) begin
                    result_next.kind = wfd_pkg::KIND_EMPTY;
                    result_next.last = 1'b1;
                    phase_next       = wfd_pkg::PH_HDR0;
                    if (opcode_reg == wfd_pkg::OPC_CLOSE) begin
                        link_up_next   = 1'b0;
                        remaining_next = 16'd0;
                    end
                end else begin
                    remaining_next = known_len;
                    phase_next     = wfd_pkg::PH_DATA;
                end
            end
        end

        result_next.link_up = link_up_next;
    end

    // ---------------------------------------------------------------
    // State and output registers: advance only on an accepted request
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= wfd_pkg::PH_HDR0;
            link_up_reg     <= 1'b0;
            opcode_reg      <= 4'd0;
            mask_seen_reg   <= 1'b0;
            remaining_reg   <= 16'd0;
            length_high_reg <= 8'd0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            link_up_reg     <= link_up_next;
            opcode_reg      <= opcode_next;
            mask_seen_reg   <= mask_seen_next;
            remaining_reg   <= remaining_next;
            length_high_reg <= length_high_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset; load on accept, hold while stalled.
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = result_reg.kind;
    assign m_data_byte   = result_reg.data_byte;
    assign m_frame_type  = result_reg.frame_type;
    assign m_last        = result_reg.last;
    assign m_error_code  = result_reg.error_code;
    assign m_link_up_out = result_reg.link_up;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_drop_when_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && accept && !s_mode && !link_up_reg)
        |=> (m_valid && m_kind == wfd_pkg::KIND_DROP && !m_link_up_out))
        else $error("byte while disconnected not reported as dropped");

    a_connect_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && accept && s_mode)
        |=> (m_valid && m_kind == wfd_pkg::KIND_HDR && m_link_up_out && link_up_reg))
        else $error("connect request did not raise the link");

    a_error_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == wfd_pkg::KIND_ERR)
        |-> (!m_link_up_out && m_error_code != wfd_pkg::ERR_NONE))
        else $error("protocol error left the link up or lacks a code");

    a_data_only_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data_byte != 8'd0) |-> (m_kind == wfd_pkg::KIND_DATA))
        else $error("data byte set on a non-payload result");

    a_data_phase_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == wfd_pkg::PH_DATA) |-> (remaining_reg != 16'd0 && link_up_reg))
        else $error("payload phase with nothing left to receive");

endmodule
